/* rtl/core/tetb_pkg.sv */
// Shared types and constants for the terminal escape text buffer.
// Depends on nothing; tetb_front, tetb_back and the top level import it.
`timescale 1ns / 1ps

package tetb_pkg;

  // Opcodes of an input word.
  localparam logic [1:0] OP_FEED     = 2'd0;
  localparam logic [1:0] OP_RD_CELL  = 2'd1;
  localparam logic [1:0] OP_RD_DIRTY = 2'd2;

  // Configuration register word indexes.
  localparam logic REG_TERMINAL_MODE = 1'b0;
  localparam int unsigned PADDR_W = 3;

  // Control and special characters.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_RS    = 8'h1E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Class of a queued word, decided by the front end.
  typedef enum logic [1:0] {
    K_FEED,
    K_RD_CELL,
    K_RD_DIRTY,
    K_NOP
  } kind_e;

  // One classified word waiting for the back end.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [4:0] row;
    logic [6:0] col;
  } item_t;

endpackage

/* rtl/core/tetb_in_if.sv */
// Input channel: opcode, fed byte and read address with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface tetb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, opcode, data_byte, read_row, read_col, input ready);
  modport sink (input valid, opcode, data_byte, read_row, read_col, output ready);
endinterface

/* rtl/core/tetb_out_if.sv */
// Result channel: read data and cursor position with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface tetb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic       row_dirty;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;

  modport source (output valid, cell_char, row_dirty, cursor_row, cursor_col, input ready);
  modport sink (input valid, cell_char, row_dirty, cursor_row, cursor_col, output ready);
endinterface

/* rtl/core/tetb_front.sv */
// Front end: accepts input words, classifies them and queues them.
// Depends on tetb_pkg and tetb_in_if.
`timescale 1ns / 1ps

module tetb_front #(
  parameter int ROWS = 24,
  parameter int COLS = 80
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           busy_i,
  tetb_in_if.sink        in_i,
  output logic           q_valid_o,
  output tetb_pkg::item_t q_item_o,
  input  logic           q_pop_i
);
  import tetb_pkg::*;

  item_t      fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  item_t      cls;
  logic       push;

  // Classify the word; out-of-range reads become no-ops.
  always_comb begin
    cls.data_byte = in_i.data_byte;
    cls.row       = in_i.read_row;
    cls.col       = in_i.read_col;
    case (in_i.opcode)
      OP_FEED:     cls.kind = K_FEED;
      OP_RD_CELL:  cls.kind = (32'(in_i.read_row) < ROWS && 32'(in_i.read_col) < COLS)
                              ? K_RD_CELL : K_NOP;
      OP_RD_DIRTY: cls.kind = (32'(in_i.read_row) < ROWS) ? K_RD_DIRTY : K_NOP;
      default:     cls.kind = K_NOP;
    endcase
  end

  assign in_i.ready = (count_q != 2'd2) && !busy_i;
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = fifo_q[rptr_q];

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= cls;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (q_pop_i) rptr_q <= !rptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

/* rtl/core/tetb_back.sv */
// Back end: escape parser, cursor, screen memory sweeps and result register.
// Depends on tetb_pkg and tetb_out_if.
`timescale 1ns / 1ps

module tetb_back #(
  parameter int ROWS       = 24,
  parameter int COLS       = 80,
  parameter int TAB_WIDTH  = 8,
  parameter int CSI_VALUES = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            q_valid_i,
  input  tetb_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            busy_o,
  tetb_out_if.source      out_o
);
  import tetb_pkg::*;

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(COLS);
  localparam int IW = $clog2(CSI_VALUES);
  localparam int NW = $clog2(CSI_VALUES + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_TAB    = 3'd3;
  localparam logic [2:0] S_RDCELL = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Parser states.
  localparam logic [2:0] PS_TEXT    = 3'd0;
  localparam logic [2:0] PS_ESC     = 3'd1;
  localparam logic [2:0] PS_CSI     = 3'd2;
  localparam logic [2:0] PS_ROWADDR = 3'd3;
  localparam logic [2:0] PS_COLADDR = 3'd4;

  // Escape command bytes.
  localparam logic [7:0] CMD_CSI     = 8'h5B;
  localparam logic [7:0] CMD_NEL     = 8'h45;
  localparam logic [7:0] CMD_SAVE    = 8'h37;
  localparam logic [7:0] CMD_RESTORE = 8'h38;
  localparam logic [7:0] CMD_ADDR    = 8'h3D;
  localparam logic [7:0] CMD_EOL     = 8'h54;
  localparam logic [7:0] CMD_EOS     = 8'h59;
  localparam logic [7:0] CMD_CLEAR   = 8'h2A;

  // CSI final bytes.
  localparam logic [7:0] FIN_CUU = 8'h41;
  localparam logic [7:0] FIN_CUD = 8'h42;
  localparam logic [7:0] FIN_CUF = 8'h43;
  localparam logic [7:0] FIN_CUB = 8'h44;
  localparam logic [7:0] FIN_CUP = 8'h48;
  localparam logic [7:0] FIN_HVP = 8'h66;
  localparam logic [7:0] FIN_ED  = 8'h4A;
  localparam logic [7:0] FIN_EL  = 8'h4B;

  logic [2:0]    state_q, state_d;
  logic          init_q, init_d;
  logic [RW-1:0] cur_row_q, cur_row_d, sav_row_q, sav_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d, sav_col_q, sav_col_d;
  logic [2:0]    ps_q, ps_d;
  logic          skip_q, skip_d;
  logic [15:0]   csi_val_q [CSI_VALUES];
  logic [15:0]   csi_val_d [CSI_VALUES];
  logic          csi_seen_q [CSI_VALUES];
  logic          csi_seen_d [CSI_VALUES];
  logic [NW-1:0] csi_cnt_q, csi_cnt_d;
  logic [IW-1:0] csi_idx_q, csi_idx_d;
  logic [7:0]    addr_row_q, addr_row_d;
  logic          dirty_q [ROWS];
  logic          dirty_d [ROWS];
  logic [AW-1:0] cnt_q, cnt_d, fend_q, fend_d, wa_q, wa_d;
  logic          pend_q, pend_d;
  logic [7:0]    res_char_q, res_char_d;
  logic          res_dirty_q, res_dirty_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q;
  logic          out_dirty_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic          out_load;

  // Screen memory ports.
  logic [7:0]    mem [N];
  logic [7:0]    mem_rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic [AW-1:0] cur_addr, row_base;

  assign row_base = AW'(32'(cur_row_q) * COLS);
  assign cur_addr = row_base + AW'(cur_col_q);
  assign busy_o   = init_q;

  // Clamp a signed row or column onto the screen.
  function automatic logic [RW-1:0] clamp_row(input logic signed [17:0] r);
    if (r < 18'sd0) return '0;
    if (r >= $signed(18'(ROWS))) return RW'(ROWS - 1);
    return r[RW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_col(input logic signed [17:0] c);
    if (c < 18'sd0) return '0;
    if (c >= $signed(18'(COLS))) return CW'(COLS - 1);
    return c[CW-1:0];
  endfunction

  // True when a column sits on a tab stop.
  function automatic logic at_tab_col(input logic [CW:0] x);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= COLS; k++) begin
      if ((k % TAB_WIDTH) == 0 && x == (CW + 1)'(k)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Main sequencer and parser.
  always_comb begin
    logic [7:0]           b;
    logic                 ground, job_clear, job_fill, job_nl, job_tab;
    logic [AW-1:0]        f_start, f_end;
    logic [RW-1:0]        d_lo, d_hi;
    logic [15:0]          a0, a1;
    logic [19:0]          prod;
    logic [IW-1:0]        nidx;
    logic signed [17:0]   mr, mc;

    state_d     = state_q;
    init_d      = init_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    sav_row_d   = sav_row_q;
    sav_col_d   = sav_col_q;
    ps_d        = ps_q;
    skip_d      = skip_q;
    csi_val_d   = csi_val_q;
    csi_seen_d  = csi_seen_q;
    csi_cnt_d   = csi_cnt_q;
    csi_idx_d   = csi_idx_q;
    addr_row_d  = addr_row_q;
    dirty_d     = dirty_q;
    cnt_d       = cnt_q;
    fend_d      = fend_q;
    wa_d        = wa_q;
    pend_d      = pend_q;
    res_char_d  = res_char_q;
    res_dirty_d = res_dirty_q;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = CH_SPACE;
    raddr       = cnt_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    b           = q_item_i.data_byte;
    ground      = 1'b0;
    job_clear   = 1'b0;
    job_fill    = 1'b0;
    job_nl      = 1'b0;
    job_tab     = 1'b0;
    f_start     = '0;
    f_end       = AW'(N - 1);
    d_lo        = '0;
    d_hi        = RW'(ROWS - 1);
    a0          = (csi_cnt_q > NW'(0) && csi_seen_q[0]) ? csi_val_q[0] : 16'd0;
    a1          = (csi_cnt_q > NW'(1) && csi_seen_q[1]) ? csi_val_q[1] : 16'd0;
    prod        = '0;
    nidx        = csi_idx_q;
    mr          = '0;
    mc          = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          res_char_d  = 8'd0;
          res_dirty_d = 1'b0;
          case (q_item_i.kind)
            K_RD_CELL: begin
              raddr   = AW'(32'(q_item_i.row) * COLS + 32'(q_item_i.col));
              state_d = S_RDCELL;
            end
            K_RD_DIRTY: begin
              res_dirty_d = dirty_q[RW'(q_item_i.row)];
              dirty_d[RW'(q_item_i.row)] = 1'b0;
              state_d = S_DONE;
            end
            K_FEED: begin
              // Parser: controls that act in any state come first.
              if (b == CH_ESC) begin
                ps_d = PS_ESC;
              end else if (b == CH_CAN) begin
                ps_d   = PS_TEXT;
                skip_d = 1'b0;
              end else if (b == CH_SUB) begin
                ps_d   = PS_TEXT;
                skip_d = 1'b0;
                if (mode_i) job_clear = 1'b1;
              end else if (ps_q == PS_ROWADDR) begin
                addr_row_d = b;
                ps_d       = PS_COLADDR;
              end else if (ps_q == PS_COLADDR) begin
                mr        = $signed({10'd0, addr_row_q}) - 18'sd32;
                mc        = $signed({10'd0, b}) - 18'sd32;
                cur_row_d = clamp_row(mr);
                cur_col_d = clamp_col(mc);
                ps_d      = PS_TEXT;
              end else if (b < CH_SPACE && ps_q != PS_TEXT) begin
                ground = 1'b1;
              end else if (ps_q == PS_ESC) begin
                ps_d = PS_TEXT;
                case (b)
                  CMD_CSI: begin
                    ps_d      = PS_CSI;
                    csi_cnt_d = '0;
                    csi_idx_d = '0;
                    skip_d    = 1'b0;
                    for (int i = 0; i < CSI_VALUES; i++) begin
                      csi_val_d[i]  = 16'd0;
                      csi_seen_d[i] = 1'b0;
                    end
                  end
                  CMD_NEL: job_nl = 1'b1;
                  CMD_SAVE: begin
                    sav_row_d = cur_row_q;
                    sav_col_d = cur_col_q;
                  end
                  CMD_RESTORE: begin
                    cur_row_d = sav_row_q;
                    cur_col_d = sav_col_q;
                  end
                  CMD_ADDR: ps_d = PS_ROWADDR;
                  CMD_EOL: begin
                    job_fill = 1'b1;
                    f_start  = cur_addr;
                    f_end    = row_base + AW'(COLS - 1);
                    d_lo     = cur_row_q;
                    d_hi     = cur_row_q;
                  end
                  CMD_EOS: begin
                    job_fill = 1'b1;
                    f_start  = cur_addr;
                    d_lo     = cur_row_q;
                  end
                  CMD_CLEAR: job_clear = 1'b1;
                  default: ;
                endcase
              end else if (ps_q == PS_CSI) begin
                if (skip_q) begin
                  if (b inside {[8'h40:8'h7E]}) begin
                    skip_d = 1'b0;
                    ps_d   = PS_TEXT;
                  end
                end else if (b inside {[8'h30:8'h39]}) begin
                  prod = ({4'd0, csi_val_q[csi_idx_q]} << 3)
                       + ({4'd0, csi_val_q[csi_idx_q]} << 1) + 20'(b - CH_ZERO);
                  csi_val_d[csi_idx_q]  = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                  csi_seen_d[csi_idx_q] = 1'b1;
                  if (csi_cnt_q < NW'(csi_idx_q) + NW'(1)) csi_cnt_d = NW'(csi_idx_q) + NW'(1);
                end else if (b == CH_SEMI) begin
                  if (csi_idx_q < IW'(CSI_VALUES - 1)) nidx = csi_idx_q + IW'(1);
                  csi_idx_d = nidx;
                  if (csi_cnt_q < NW'(nidx) + NW'(1)) csi_cnt_d = NW'(nidx) + NW'(1);
                end else if (b inside {[8'h40:8'h7E]}) begin
                  ps_d = PS_TEXT;
                  case (b)
                    FIN_CUU: begin
                      if (!(csi_cnt_q > NW'(0) && csi_seen_q[0])) a0 = 16'd1;
                      cur_row_d = clamp_row($signed({13'd0, cur_row_q}) - $signed({2'd0, a0}));
                    end
                    FIN_CUD: begin
                      if (!(csi_cnt_q > NW'(0) && csi_seen_q[0])) a0 = 16'd1;
                      cur_row_d = clamp_row($signed({13'd0, cur_row_q}) + $signed({2'd0, a0}));
                    end
                    FIN_CUF: begin
                      if (!(csi_cnt_q > NW'(0) && csi_seen_q[0])) a0 = 16'd1;
                      cur_col_d = clamp_col($signed(18'(cur_col_q)) + $signed({2'd0, a0}));
                    end
                    FIN_CUB: begin
                      if (!(csi_cnt_q > NW'(0) && csi_seen_q[0])) a0 = 16'd1;
                      cur_col_d = clamp_col($signed(18'(cur_col_q)) - $signed({2'd0, a0}));
                    end
                    FIN_CUP, FIN_HVP: begin
                      if (!(csi_cnt_q > NW'(0) && csi_seen_q[0])) a0 = 16'd1;
                      if (!(csi_cnt_q > NW'(1) && csi_seen_q[1])) a1 = 16'd1;
                      cur_row_d = clamp_row($signed({2'd0, a0}) - 18'sd1);
                      cur_col_d = clamp_col($signed({2'd0, a1}) - 18'sd1);
                    end
                    FIN_ED: begin
                      if (a0 == 16'd0) begin
                        job_fill = 1'b1;
                        f_start  = cur_addr;
                        d_lo     = cur_row_q;
                      end else if (a0 == 16'd1) begin
                        job_fill = 1'b1;
                        f_end    = cur_addr;
                        d_hi     = cur_row_q;
                      end else if (a0 == 16'd2) begin
                        job_fill = 1'b1;
                      end
                    end
                    FIN_EL: begin
                      d_lo = cur_row_q;
                      d_hi = cur_row_q;
                      if (a0 == 16'd0) begin
                        job_fill = 1'b1;
                        f_start  = cur_addr;
                        f_end    = row_base + AW'(COLS - 1);
                      end else if (a0 == 16'd1) begin
                        job_fill = 1'b1;
                        f_start  = row_base;
                        f_end    = cur_addr;
                      end else if (a0 == 16'd2) begin
                        job_fill = 1'b1;
                        f_start  = row_base;
                        f_end    = row_base + AW'(COLS - 1);
                      end
                    end
                    default: ;
                  endcase
                end else begin
                  skip_d = 1'b1;
                end
              end else begin
                ground = 1'b1;
              end

              // Ground-state byte handling.
              if (ground) begin
                case (b)
                  CH_BS: if (cur_col_q != '0) cur_col_d = cur_col_q - CW'(1);
                  CH_TAB: job_tab = 1'b1;
                  CH_LF: job_nl = 1'b1;
                  CH_VT: if (mode_i && cur_row_q != '0) cur_row_d = cur_row_q - RW'(1);
                  CH_FF: begin
                    if (!mode_i) job_clear = 1'b1;
                    else if (32'(cur_col_q) < COLS - 1) cur_col_d = cur_col_q + CW'(1);
                  end
                  CH_CR: cur_col_d = '0;
                  CH_RS: begin
                    cur_col_d = '0;
                    cur_row_d = '0;
                  end
                  default: begin
                    if (b >= CH_SPACE) begin
                      we    = 1'b1;
                      wdata = b;
                      dirty_d[cur_row_q] = 1'b1;
                      if (32'(cur_col_q) + 1 >= COLS) job_nl = 1'b1;
                      else cur_col_d = cur_col_q + CW'(1);
                    end
                  end
                endcase
              end

              // Start the job this byte needs.
              if (job_clear) begin
                cur_row_d = '0;
                cur_col_d = '0;
                cnt_d     = '0;
                fend_d    = AW'(N - 1);
                for (int r = 0; r < ROWS; r++) dirty_d[r] = 1'b1;
                state_d   = S_FILL;
              end else if (job_fill) begin
                cnt_d  = f_start;
                fend_d = f_end;
                for (int r = 0; r < ROWS; r++) begin
                  if (RW'(r) >= d_lo && RW'(r) <= d_hi) dirty_d[r] = 1'b1;
                end
                state_d = S_FILL;
              end else if (job_nl) begin
                cur_col_d = '0;
                if (32'(cur_row_q) < ROWS - 1) begin
                  cur_row_d = cur_row_q + RW'(1);
                  state_d   = S_DONE;
                end else begin
                  for (int r = 0; r < ROWS; r++) dirty_d[r] = 1'b1;
                  cnt_d   = '0;
                  pend_d  = 1'b0;
                  state_d = S_SCROLL;
                end
              end else if (job_tab) begin
                state_d = S_TAB;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Write spaces over a linear range of cells.
      S_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == fend_q) begin
          state_d = init_q ? S_IDLE : S_DONE;
          init_d  = 1'b0;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      // Move every row up by one, one cell per cycle, then blank the last row.
      S_SCROLL: begin
        if (32'(cnt_q) < N - COLS) begin
          raddr  = cnt_q + AW'(COLS);
          cnt_d  = cnt_q + AW'(1);
          wa_d   = cnt_q;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            fend_d  = AW'(N - 1);
            state_d = S_FILL;
          end
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = mem_rd_q;
        end
      end

      // Tab: one space per cycle up to the next stop or the line end.
      S_TAB: begin
        we = 1'b1;
        dirty_d[cur_row_q] = 1'b1;
        if (32'(cur_col_q) + 1 >= COLS) begin
          cur_col_d = '0;
          if (32'(cur_row_q) < ROWS - 1) begin
            cur_row_d = cur_row_q + RW'(1);
            state_d   = S_DONE;
          end else begin
            for (int r = 0; r < ROWS; r++) dirty_d[r] = 1'b1;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCROLL;
          end
        end else begin
          cur_col_d = cur_col_q + CW'(1);
          if (at_tab_col((CW + 1)'(cur_col_q) + (CW + 1)'(1))) state_d = S_DONE;
        end
      end

      // Registered memory data of a cell read.
      S_RDCELL: begin
        res_char_d = mem_rd_q;
        state_d    = S_DONE;
      end

      // Hand the result over once the output register is free.
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output word register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_char_q;
  assign out_o.row_dirty  = out_dirty_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.cursor_col = out_col_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q  <= res_char_q;
      out_dirty_q <= res_dirty_q;
      out_row_q   <= 5'(cur_row_q);
      out_col_q   <= 7'(cur_col_q);
    end
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    mem_rd_q <= mem[raddr];
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    wa_q        <= wa_d;
    res_char_q  <= res_char_d;
    res_dirty_q <= res_dirty_d;
  end

  // Control state; the reset sweep blanks every cell from address 0 to the end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      fend_q      <= AW'(N - 1);
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      sav_row_q   <= '0;
      sav_col_q   <= '0;
      ps_q        <= PS_TEXT;
      skip_q      <= 1'b0;
      csi_cnt_q   <= '0;
      csi_idx_q   <= '0;
      addr_row_q  <= 8'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CSI_VALUES; i++) begin
        csi_val_q[i]  <= 16'd0;
        csi_seen_q[i] <= 1'b0;
      end
      for (int r = 0; r < ROWS; r++) dirty_q[r] <= 1'b1;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      fend_q      <= fend_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      sav_row_q   <= sav_row_d;
      sav_col_q   <= sav_col_d;
      ps_q        <= ps_d;
      skip_q      <= skip_d;
      csi_cnt_q   <= csi_cnt_d;
      csi_idx_q   <= csi_idx_d;
      addr_row_q  <= addr_row_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      csi_val_q   <= csi_val_d;
      csi_seen_q  <= csi_seen_d;
      dirty_q     <= dirty_d;
    end
  end

endmodule

/* rtl/core/terminal_escape_text_buffer_top.sv */
// Channel      | Dir | Handshake     | Word
// in_i         | in  | valid/ready   | opcode, data_byte, read_row, read_col
// out_o        | out | valid/ready   | cell_char, row_dirty, cursor_row, cursor_col
// APB          | in  | psel/penable  | terminal_mode at word 0
//
// Top level of the terminal text buffer; depends on tetb_pkg, tetb_in_if, tetb_out_if,
// tetb_front and tetb_back. One word at a time is executed by the back end.
// An erase or clear writes spaces over the blanked cells one after another, a scroll
// copies every row up by one and then blanks the last row, and a tab writes spaces up
// to the next stop or the line end. After reset the memory is swept to spaces and no
// word is accepted until the sweep ends. A two-entry queue and the output register
// decouple stalls.
`timescale 1ns / 1ps

module terminal_escape_text_buffer_top #(
  parameter int SCREEN_ROWS = 24,
  parameter int SCREEN_COLS = 80,
  parameter int TAB_WIDTH   = 8,
  parameter int CSI_VALUES  = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tetb_in_if.sink                       in_i,
  tetb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tetb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tetb_pkg::*;

  logic  mode_q;
  logic  q_valid, q_pop, busy;
  item_t q_item;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_TERMINAL_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_TERMINAL_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  // Front end: classify and queue.
  tetb_front #(
    .ROWS (SCREEN_ROWS),
    .COLS (SCREEN_COLS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_i    (busy),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back end: parser, screen and results.
  tetb_back #(
    .ROWS       (SCREEN_ROWS),
    .COLS       (SCREEN_COLS),
    .TAB_WIDTH  (TAB_WIDTH),
    .CSI_VALUES (CSI_VALUES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .busy_o    (busy),
    .out_o     (out_o)
  );

endmodule
